// ===== rtl/dkp_pkg.sv =====
// Package for the DNA k-mer 2-bit packer: item types, sequence state type,
// register indexes, reset values and the byte classifier.
// Used by every file of the block; depends on nothing.
`timescale 1ns / 1ps

package dkp_pkg;

   localparam int MAX_WORD_LEN       = 32;
   localparam int WORD_COUNT_WIDTH   = 16;
   localparam int WORD_LEN_WIDTH     = 6;
   localparam int WORD_CODE_WIDTH    = 64;
   localparam int PACK_WIDTH         = 2 * MAX_WORD_LEN;
   localparam int BASE_COUNT_WIDTH   = $clog2(MAX_WORD_LEN + 1);
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = WORD_COUNT_WIDTH;

   localparam logic [WORD_LEN_WIDTH-1:0]   WORD_LEN_RESET      = WORD_LEN_WIDTH'(8);
   localparam logic [WORD_COUNT_WIDTH-1:0] WORDS_PER_SEQ_RESET = WORD_COUNT_WIDTH'(4);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORD_LEN      = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORDS_PER_SEQ = CSR_INDEX_WIDTH'(1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef enum logic {
      KIND_WORD  = 1'b0,
      KIND_ABORT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CLS_BASE,
      CLS_NEWLINE,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [1:0]     code;
   } char_info_type;

   typedef struct packed {
      logic       new_region;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic                       kind;
      logic [WORD_CODE_WIDTH-1:0] word_code;
      logic                       last_word;
   } rsp_type;

   typedef struct packed {
      logic                        active;
      logic [BASE_COUNT_WIDTH-1:0] base_count;
      logic [WORD_COUNT_WIDTH-1:0] word_count;
      logic [PACK_WIDTH-1:0]       pack;
   } seq_state_type;

   localparam seq_state_type SEQ_CLEAR = '{
      active:     1'b0,
      base_count: '0,
      word_count: '0,
      pack:       '0
   };

   function automatic char_info_type classify(input logic [7:0] b);
      char_info_type info;
      info.cls  = CLS_BASE;
      info.code = 2'd0;
      case (b)
         "A", "a": info.code = 2'd0;
         "T", "t": info.code = 2'd1;
         "C", "c": info.code = 2'd2;
         "G", "g": info.code = 2'd3;
         CHAR_NEWLINE: info.cls = CLS_NEWLINE;
         default: info.cls = CLS_OTHER;
      endcase
      return info;
   endfunction

endpackage

// ===== rtl/dkp_step.sv =====
// Per-byte sequence logic of the k-mer packer: classifies one byte, shifts
// the base into the current word and updates the base and word counters.
// Purely combinational; depends on dkp_pkg.
`timescale 1ns / 1ps

module dkp_step (
   input  dkp_pkg::seq_state_type                  state,
   input  dkp_pkg::req_type                        req,
   input  logic [dkp_pkg::WORD_LEN_WIDTH-1:0]      word_len,
   input  logic [dkp_pkg::WORD_COUNT_WIDTH-1:0]    words_per_seq,
   output dkp_pkg::seq_state_type                  next_state,
   output logic                                    res_valid,
   output dkp_pkg::rsp_type                        res
);
   import dkp_pkg::*;

   seq_state_type               start;
   char_info_type               info;
   logic [BASE_COUNT_WIDTH-1:0] eff_word_len;
   logic [WORD_COUNT_WIDTH-1:0] eff_words;
   logic [BASE_COUNT_WIDTH-1:0] bases_next;
   logic [WORD_COUNT_WIDTH-1:0] words_next;
   logic [PACK_WIDTH-1:0]       pack_next;

   always_comb begin
      if (word_len == '0) begin
         eff_word_len = BASE_COUNT_WIDTH'(1);
      end else if (word_len > WORD_LEN_WIDTH'(MAX_WORD_LEN)) begin
         eff_word_len = BASE_COUNT_WIDTH'(MAX_WORD_LEN);
      end else begin
         eff_word_len = BASE_COUNT_WIDTH'(word_len);
      end
      eff_words = (words_per_seq == '0) ? WORD_COUNT_WIDTH'(1) : words_per_seq;
   end

   always_comb begin
      start = state;
      if (req.new_region) begin
         start        = SEQ_CLEAR;
         start.active = 1'b1;
      end
      info       = classify(req.char_byte);
      pack_next  = {start.pack[PACK_WIDTH-3:0], info.code};
      bases_next = start.base_count + BASE_COUNT_WIDTH'(1);
      words_next = start.word_count + WORD_COUNT_WIDTH'(1);

      next_state    = start;
      res_valid     = 1'b0;
      res.kind      = KIND_WORD;
      res.word_code = WORD_CODE_WIDTH'(pack_next);
      res.last_word = 1'b0;

      if (start.active) begin
         case (info.cls)
            CLS_NEWLINE: begin
               next_state = start;
            end
            CLS_BASE: begin
               if (bases_next < eff_word_len) begin
                  next_state.pack       = pack_next;
                  next_state.base_count = bases_next;
               end else begin
                  res_valid             = 1'b1;
                  next_state.pack       = '0;
                  next_state.base_count = '0;
                  next_state.word_count = words_next;
                  if (words_next >= eff_words) begin
                     res.last_word = 1'b1;
                     next_state    = SEQ_CLEAR;
                  end
               end
            end
            default: begin
               res_valid     = 1'b1;
               res.kind      = KIND_ABORT;
               res.word_code = '0;
               next_state    = SEQ_CLEAR;
            end
         endcase
      end
   end

endmodule

// ===== rtl/dna_kmer_2bit_packer.sv =====
// Top level of the DNA k-mer 2-bit packer: configuration registers, sequence
// state registers and a two-entry result buffer. Depends on dkp_pkg, dkp_step.
//
// The block takes one text byte per cycle unless stalled and returns a result
// item for the byte that causes it: a packed word when word_len bases have
// been collected, or an abort item when a byte other than a base or a newline
// arrives. The whole per-byte update is one pass through the classifier, the
// 2-bit shift and the counter compare, so one item can be accepted every
// clock unless stalled. Results land in an output register backed by one skid
// entry; req_stall rises only while both are held by a stalled consumer.
// Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps

module dna_kmer_2bit_packer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dkp_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dkp_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dkp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dkp_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import dkp_pkg::*;

   logic [WORD_LEN_WIDTH-1:0]   word_len_ff, word_len_in;
   logic [WORD_COUNT_WIDTH-1:0] words_per_seq_ff, words_per_seq_in;
   seq_state_type               state_ff, state_in, step_state;
   logic                        step_valid;
   rsp_type                     step_res;
   logic                        out_valid_ff, out_valid_in;
   rsp_type                     out_ff, out_in;
   logic                        skid_valid_ff, skid_valid_in;
   rsp_type                     skid_ff, skid_in;
   logic                        accept;
   logic                        out_free;
   logic                        res_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      word_len_in      = word_len_ff;
      words_per_seq_in = words_per_seq_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WORD_LEN:      word_len_in      = csr_data[WORD_LEN_WIDTH-1:0];
            CSR_WORDS_PER_SEQ: words_per_seq_in = csr_data[WORD_COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   dkp_step u_step (
      .state         (state_ff),
      .req           (req_payload),
      .word_len      (word_len_ff),
      .words_per_seq (words_per_seq_ff),
      .next_state    (step_state),
      .res_valid     (step_valid),
      .res           (step_res)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign res_valid = accept && step_valid;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = accept ? step_state : state_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = step_res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff      <= WORD_LEN_RESET;
         words_per_seq_ff <= WORDS_PER_SEQ_RESET;
         state_ff         <= SEQ_CLEAR;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         word_len_ff      <= word_len_in;
         words_per_seq_ff <= words_per_seq_in;
         state_ff         <= state_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== rtl/dkp_checker.sv =====
// Port-level checks for the DNA k-mer 2-bit packer, attached by bind.
// Depends on dkp_pkg and the top level dna_kmer_2bit_packer.
`timescale 1ns / 1ps

module dkp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dkp_pkg::rsp_type rsp_payload
);
   import dkp_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall pending right after reset");

   a_abort_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_ABORT |->
         rsp_payload.word_code == '0 && !rsp_payload.last_word)
      else $error("abort item carries a word or a last flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result item withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result item changed");

endmodule

bind dna_kmer_2bit_packer dkp_checker u_dkp_checker (.*);

// ===== tb/tb_dna_kmer_2bit_packer.sv =====
// Self-checking testbench for dna_kmer_2bit_packer: random text bytes, stalls and
// register settings, with a scoreboard class that predicts every packed word.
// Depends on dkp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_dna_kmer_2bit_packer;
   import dkp_pkg::*;

   class kmer_scoreboard;
      logic [WORD_LEN_WIDTH-1:0]   word_len;
      logic [WORD_COUNT_WIDTH-1:0] words_per_seq;
      bit                          active;
      logic [5:0]                  base_count;
      logic [WORD_COUNT_WIDTH-1:0] word_count;
      logic [63:0]                 pack;
      rsp_type                     due_words[$];
      int                          mismatches;

      function new();
         word_len      = WORD_LEN_RESET;
         words_per_seq = WORDS_PER_SEQ_RESET;
         active        = 1'b0;
         mismatches    = 0;
         restart_seq();
      endfunction

      function void restart_seq();
         base_count = '0;
         word_count = '0;
         pack       = '0;
      endfunction

      static function char_class_type sort_byte(input logic [7:0] b, output logic [1:0] code);
         code = 2'd0;
         case (b)
            "A", "a": return CLS_BASE;
            "T", "t": begin
               code = 2'd1;
               return CLS_BASE;
            end
            "C", "c": begin
               code = 2'd2;
               return CLS_BASE;
            end
            "G", "g": begin
               code = 2'd3;
               return CLS_BASE;
            end
            CHAR_NEWLINE: return CLS_NEWLINE;
            default: return CLS_OTHER;
         endcase
      endfunction

      function int len_eff();
         if (word_len == 0) return 1;
         if (word_len > MAX_WORD_LEN) return MAX_WORD_LEN;
         return word_len;
      endfunction

      function int seq_eff();
         if (words_per_seq == 0) return 1;
         return words_per_seq;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
         if (idx == CSR_WORD_LEN) word_len = data[WORD_LEN_WIDTH-1:0];
         else if (idx == CSR_WORDS_PER_SEQ) words_per_seq = data;
      endfunction

      // Returns 1 unless the byte was dropped while no sequence was open.
      function bit note_byte(req_type item);
         rsp_type        word;
         logic [1:0]     code;
         char_class_type cls;
         if (item.new_region) begin
            active = 1'b1;
            restart_seq();
         end
         if (!active) return 1'b0;
         cls = sort_byte(item.char_byte, code);
         if (cls == CLS_NEWLINE) return 1'b1;
         if (cls == CLS_OTHER) begin
            active = 1'b0;
            restart_seq();
            word.kind      = KIND_ABORT;
            word.word_code = '0;
            word.last_word = 1'b0;
            due_words.push_back(word);
            return 1'b1;
         end
         pack       = {pack[61:0], code};
         base_count = base_count + 1'b1;
         if (base_count < len_eff()) return 1'b1;
         word.kind      = KIND_WORD;
         word.word_code = pack;
         word.last_word = 1'b0;
         pack           = '0;
         base_count     = '0;
         word_count     = word_count + 1'b1;
         if (word_count >= seq_eff()) begin
            word.last_word = 1'b1;
            active         = 1'b0;
            restart_seq();
         end
         due_words.push_back(word);
         return 1'b1;
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind=%0d word_code=%h last_word=%0d",
                        got.kind, got.word_code, got.last_word);
            return;
         end
         want = due_words.pop_front();
         if (got.kind !== want.kind || got.word_code !== want.word_code ||
             got.last_word !== want.last_word) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected kind=%0d word_code=%h last_word=%0d,",
                        want.kind, want.word_code, want.last_word);
               $display("          got kind=%0d word_code=%h last_word=%0d",
                        got.kind, got.word_code, got.last_word);
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_payload;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   kmer_scoreboard sb;
   bit             no_idle;
   int             bytes_used;

   dna_kmer_2bit_packer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("** dna_kmer_2bit_packer: FAILED **");
      $finish;
   end

   function automatic logic [7:0] base_char(input logic [1:0] code, input bit lower);
      logic [7:0] c;
      case (code)
         2'd0: c = "A";
         2'd1: c = "T";
         2'd2: c = "C";
         default: c = "G";
      endcase
      return lower ? (c | 8'h20) : c;
   endfunction

   task automatic send_item(input logic fresh, input logic [7:0] ch);
      int      gap;
      req_type item;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      item.new_region = fresh;
      item.char_byte  = ch;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      if (sb.note_byte(item)) bytes_used++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_sequence();
      int         style;
      int         nbases;
      int         total;
      int         mark;
      int         i;
      logic [1:0] code;
      logic [7:0] bad;
      nbases = sb.len_eff() * sb.seq_eff();
      if (nbases > 200) nbases = sb.len_eff() * $urandom_range(1, 3);
      style   = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 4) == 0);
      if (style == 9) begin
         repeat ($urandom_range(1, 8))
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         return;
      end
      total = nbases + $urandom_range(0, 2);
      mark  = (style >= 6) ? $urandom_range(0, nbases - 1) : -1;
      for (i = 0; i < total; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(1'b0, CHAR_NEWLINE);
         if (i == mark && style == 6) begin
            do bad = 8'($urandom_range(0, 255));
            while (kmer_scoreboard::sort_byte(bad, code) != CLS_OTHER);
            send_item(i == 0, bad);
            break;
         end
         if (i == mark && style == 8) break;
         send_item(i == 0 || (i == mark && style == 7),
                   base_char(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         int hold;
         hold = no_idle ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_payload);
   end

   initial begin
      int                   p;
      int                   goal;
      logic [5:0]           wl;
      logic [15:0]          wps;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      no_idle     = 1'b0;
      bytes_used  = 0;
      sb          = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: no region open, one-base words, restart with a bad byte,
      // out-of-range settings, and registers changed in the middle of a sequence.
      send_item(1'b0, "A");
      settle();
      write_reg(CSR_WORD_LEN, 16'd1, 1'b0);
      write_reg(CSR_WORDS_PER_SEQ, 16'd2, 1'b1);
      send_item(1'b1, "A");
      send_item(1'b0, "t");
      send_item(1'b0, "G");
      send_item(1'b1, 8'hFF);
      send_item(1'b1, CHAR_NEWLINE);
      send_item(1'b0, "c");
      send_item(1'b0, "g");
      send_item(1'b1, 8'h00);
      settle();
      write_reg(CSR_WORD_LEN, 16'hFFC0, 1'b0);
      write_reg(CSR_WORDS_PER_SEQ, 16'h0000, 1'b1);
      send_item(1'b1, "C");
      settle();
      write_reg(CSR_WORD_LEN, 16'd4, 1'b0);
      write_reg(CSR_WORDS_PER_SEQ, 16'd3, 1'b1);
      send_item(1'b1, "a");
      send_item(1'b0, "c");
      send_item(1'b0, CHAR_NEWLINE);
      send_item(1'b0, "g");
      settle();
      write_reg(CSR_WORD_LEN, 16'd2, 1'b1);
      send_item(1'b0, "T");
      settle();
      write_reg(CSR_WORDS_PER_SEQ, 16'd1, 1'b1);
      send_item(1'b0, "A");
      send_item(1'b0, "A");
      send_item(1'b1, "G");
      send_item(1'b1, "G");
      send_item(1'b0, "C");
      send_item(1'b1, "T");
      send_item(1'b0, "N");

      for (p = 0; p < 14; p++) begin
         settle();
         case (p)
            0: wl = 6'd32;
            1: wl = 6'd1;
            2: wl = 6'd0;
            3: wl = 6'($urandom_range(33, 63));
            default: begin
               goal = $urandom_range(0, 9);
               wl = (goal == 0) ? 6'd32 : (goal == 1) ? 6'd1 : 6'($urandom_range(2, 12));
            end
         endcase
         case (p)
            4: wps = 16'hFFFF;
            5: wps = 16'h0000;
            6: wps = 16'd1;
            default: wps = ($urandom_range(0, 7) == 0 && wl <= 4) ?
                           16'($urandom_range(7, 40)) : 16'($urandom_range(1, 6));
         endcase
         write_reg(CSR_WORD_LEN, {10'($urandom_range(0, 1023)), wl}, 1'b0);
         write_reg(CSR_WORDS_PER_SEQ, wps, 1'b1);
         goal = bytes_used + 132;
         while (bytes_used < goal) send_sequence();
      end

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("** dna_kmer_2bit_packer: PASSED **");
      else
         $display("** dna_kmer_2bit_packer: FAILED **");
      $finish;
   end

endmodule
